// ===== src/aptq_pkg.sv =====
// ----------------------------------------------------------------------------
// aptq_pkg: shared types and constants of the aging priority transmit queue
// Entry layout, status codes and register indexes.
// ----------------------------------------------------------------------------
package aptq_pkg;

	localparam int QueueDepth = 16;
	localparam int IdxW = $clog2(QueueDepth);
	localparam int CntW = $clog2(QueueDepth + 1);

	localparam logic [2:0] ST_OK = 3'd0;
	localparam logic [2:0] ST_BAD_ARG = 3'd1;
	localparam logic [2:0] ST_DUPLICATE = 3'd2;
	localparam logic [2:0] ST_FULL = 3'd3;
	localparam logic [2:0] ST_EXHAUSTED = 3'd4;
	localparam logic [2:0] ST_EMPTY = 3'd5;

	localparam logic [2:0] REG_MAX_PRIORITY = 3'd0;
	localparam logic [2:0] REG_AGING_QUANTUM = 3'd1;
	localparam logic [2:0] REG_MAX_PAYLOAD = 3'd2;
	localparam logic [2:0] REG_COMMAND_CLASS = 3'd3;
	localparam logic [2:0] REG_SNAPSHOT_CLASS = 3'd4;
	localparam logic [2:0] REG_EVENT_CLASS = 3'd5;

	localparam logic [63:0] AllOnes64 = '1;

	typedef struct packed {
		logic [63:0] dispatch;
		logic [63:0] serial;
		logic [31:0] size;
		logic [31:0] handle;
		logic [7:0]  prio;
		logic [31:0] sequence_num;
		logic [31:0] epoch;
		logic [15:0] schema;
		logic [7:0]  rclass;
	} entry_t;

	// divider handshake
	typedef struct packed {
		logic        start;
		logic [63:0] dividend;
		logic [15:0] divisor;
	} div_req_t;

endpackage

// ===== src/aptq_div.sv =====
// ----------------------------------------------------------------------------
// aptq_div: shared restoring divider
// 64 by 16 bit unsigned division, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module aptq_div (
	input  logic                 clk,
	input  logic                 arst_n,
	input  aptq_pkg::div_req_t   req,
	output logic                 done,
	output logic [63:0]          quotient
);
	import aptq_pkg::*;

	logic [63:0] quo_q;
	logic [16:0] rem_q;
	logic [15:0] dsr_q;
	logic [6:0]  cnt_q;
	logic        busy_q;
	logic [16:0] trial;
	logic [17:0] diff;

	assign trial = {rem_q[15:0], quo_q[63]};
	assign diff = {1'b0, trial} - {2'b00, dsr_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q <= '0;
		end else if (req.start) begin
			busy_q <= 1'b1;
			cnt_q <= 7'd64;
		end else if (busy_q) begin
			cnt_q <= cnt_q - 7'd1;
			if (cnt_q == 7'd1) busy_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			quo_q <= req.dividend;
			rem_q <= '0;
			dsr_q <= req.divisor;
		end else if (busy_q) begin
			if (!diff[17]) begin
				rem_q <= diff[16:0];
				quo_q <= {quo_q[62:0], 1'b1};
			end else begin
				rem_q <= trial;
				quo_q <= {quo_q[62:0], 1'b0};
			end
		end
	end

	assign done = busy_q && cnt_q == 7'd1;
	assign quotient = diff[17] ? {quo_q[62:0], 1'b0} : {quo_q[62:0], 1'b1};
endmodule

// ===== src/aging_priority_tx_queue.sv =====
// ----------------------------------------------------------------------------
// aging_priority_tx_queue: transmit queue served by aged priority
// Sequencer over an entry memory and a shared serial divider.
// ----------------------------------------------------------------------------
// One word is handled at a time.
//
// - Push: each stored entry is read and then compared against the word
//   for a duplicate. The result is given after the last compare, or
//   sooner when a duplicate is found.
// - Pop: each stored entry is read and the shared divider is started;
//   its quotient ages the entry's priority. The later entries are then
//   moved down, each read and then written. The divider sets the pop time.
// - Rejected words, pops of an empty queue and pops with an exhausted
//   dispatch count answer on the next cycle.
//
// The result is held in an output register. No new word is taken until the
// result has been read.
module aging_priority_tx_queue (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	output logic         s_tready,
	input  logic [167:0] s_tdata,  // class, reserved, schema, epoch, sequence,
	                               // priority, handle, size
	input  logic         s_tuser,  // func
	output logic         m_tvalid,
	input  logic         m_tready,
	output logic [287:0] m_tdata,  // class, schema, epoch, sequence, priority,
	                               // handle, size, serial, dispatch count
	output logic [2:0]   m_tuser,  // status
	input  logic         cfg_valid,
	output logic         cfg_ready,
	input  logic [2:0]   cfg_index,
	input  logic [31:0]  cfg_data
);
	import aptq_pkg::*;

	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_PSCAN = 3'd1;
	localparam logic [2:0] S_PREAD = 3'd2;
	localparam logic [2:0] S_PDIV = 3'd3;
	localparam logic [2:0] S_SHIFT = 3'd4;
	localparam logic [2:0] S_DONE = 3'd5;
	localparam logic [2:0] S_SHWR = 3'd6;

	logic [7:0]  max_prio_q, cmd_cls_q, snap_cls_q, evt_cls_q;
	logic [15:0] quantum_q;
	logic [31:0] max_bytes_q;

	logic [2:0]       state_q;
	logic [CntW-1:0]  count_q;
	logic [63:0]      serial_q, disp_q;
	logic [IdxW-1:0]  idx_q, best_q;
	logic [7:0]       best_p_q;
	logic [63:0]      best_ser_q;
	logic             func_q;
	entry_t           in_q, rd_s1, best_e_q;
	logic             out_v_q;
	logic [2:0]       out_st_q;
	entry_t           out_e_q;

	entry_t           mem [QueueDepth];
	logic [IdxW-1:0]  rd_addr;
	logic             wr_en;
	logic [IdxW-1:0]  wr_addr;
	entry_t           wr_data;

	div_req_t         dreq;
	logic             ddone;
	logic [63:0]      dquo;

	entry_t  s_e;
	logic    cls_ok, bad;
	logic    dup;
	logic [7:0] aged;
	logic    last_idx;

	assign s_e.rclass = s_tdata[7:0];
	assign s_e.schema = s_tdata[31:16];
	assign s_e.epoch = s_tdata[63:32];
	assign s_e.sequence_num = s_tdata[95:64];
	assign s_e.prio = s_tdata[103:96];
	assign s_e.handle = s_tdata[135:104];
	assign s_e.size = s_tdata[167:136];
	assign s_e.serial = serial_q;
	assign s_e.dispatch = disp_q;

	assign cls_ok = s_e.rclass == cmd_cls_q || s_e.rclass == snap_cls_q ||
		s_e.rclass == evt_cls_q;
	assign bad = !cls_ok || s_tdata[15:8] != 8'd0 || s_e.schema == 16'd0 ||
		s_e.epoch == 32'd0 || s_e.sequence_num == 32'd0 || s_e.prio > max_prio_q ||
		s_e.handle == 32'd0 || s_e.size == 32'd0 || s_e.size > max_bytes_q;

	assign dup = rd_s1.handle == in_q.handle || (rd_s1.rclass == in_q.rclass &&
		rd_s1.schema == in_q.schema && rd_s1.epoch == in_q.epoch &&
		rd_s1.sequence_num == in_q.sequence_num);
	assign aged = (dquo >= {56'd0, rd_s1.prio}) ? 8'd0 : rd_s1.prio - dquo[7:0];
	assign last_idx = {1'b0, idx_q} == count_q - CntW'(1);

	assign s_tready = state_q == S_IDLE && !out_v_q;
	assign cfg_ready = 1'b1;

	always_comb begin
		rd_addr = idx_q;
		if (state_q == S_SHIFT) rd_addr = idx_q + IdxW'(1);
		wr_en = state_q == S_SHWR;
		wr_addr = idx_q;
		wr_data = rd_s1;
		dreq.start = state_q == S_PREAD && func_q;
		dreq.dividend = disp_q - rd_s1.dispatch;
		dreq.divisor = quantum_q == 16'd0 ? 16'd1 : quantum_q;
	end

	always_ff @(posedge clk) begin
		if (wr_en) mem[wr_addr] <= wr_data;
		else if (state_q == S_DONE && !func_q && out_st_q == ST_OK)
			mem[count_q[IdxW-1:0]] <= in_q;
		rd_s1 <= mem[rd_addr];
	end

	aptq_div u_div (
		.clk(clk), .arst_n(arst_n), .req(dreq), .done(ddone), .quotient(dquo)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_prio_q <= 8'd7;
			quantum_q <= 16'd8;
			max_bytes_q <= 32'd65536;
			cmd_cls_q <= 8'd1;
			snap_cls_q <= 8'd2;
			evt_cls_q <= 8'd3;
		end else if (cfg_valid) begin
			case (cfg_index)
				REG_MAX_PRIORITY: max_prio_q <= cfg_data[7:0];
				REG_AGING_QUANTUM: quantum_q <= cfg_data[15:0];
				REG_MAX_PAYLOAD: max_bytes_q <= cfg_data;
				REG_COMMAND_CLASS: cmd_cls_q <= cfg_data[7:0];
				REG_SNAPSHOT_CLASS: snap_cls_q <= cfg_data[7:0];
				REG_EVENT_CLASS: evt_cls_q <= cfg_data[7:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			count_q <= '0;
			serial_q <= 64'd1;
			disp_q <= '0;
			idx_q <= '0;
			best_q <= '0;
			best_p_q <= '0;
			best_ser_q <= '0;
			best_e_q <= '0;
			in_q <= '0;
			out_e_q <= '0;
			out_v_q <= 1'b0;
			out_st_q <= ST_OK;
			func_q <= 1'b0;
		end else begin
			if (out_v_q && m_tready) out_v_q <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (s_tvalid && s_tready) begin
						func_q <= s_tuser;
						in_q <= s_e;
						idx_q <= '0;
						out_e_q <= '0;
						if (!s_tuser) begin
							if (bad) begin
								out_st_q <= ST_BAD_ARG;
								out_v_q <= 1'b1;
							end else if (count_q == '0) begin
								out_st_q <= ST_OK;
								state_q <= S_DONE;
							end else begin
								state_q <= S_PSCAN;
							end
						end else if (count_q == '0) begin
							out_st_q <= ST_EMPTY;
							out_v_q <= 1'b1;
						end else if (disp_q == AllOnes64) begin
							out_st_q <= ST_EXHAUSTED;
							out_v_q <= 1'b1;
						end else begin
							best_p_q <= 8'hff;
							best_ser_q <= AllOnes64;
							state_q <= S_PSCAN;
						end
					end
				end
				S_PSCAN: begin
					// wait for the registered memory read
					state_q <= S_PREAD;
				end
				S_PREAD: begin
					if (!func_q) begin
						if (dup) begin
							out_st_q <= ST_DUPLICATE;
							out_v_q <= 1'b1;
							state_q <= S_IDLE;
						end else if (last_idx) begin
							if (count_q[CntW-1]) out_st_q <= ST_FULL;
							else if (serial_q == AllOnes64) out_st_q <= ST_EXHAUSTED;
							else out_st_q <= ST_OK;
							state_q <= S_DONE;
						end else begin
							idx_q <= idx_q + IdxW'(1);
							state_q <= S_PSCAN;
						end
					end else begin
						state_q <= S_PDIV;
					end
				end
				S_PDIV: begin
					if (ddone) begin
						if (aged < best_p_q || (aged == best_p_q && rd_s1.serial < best_ser_q)
							|| idx_q == '0) begin
							best_q <= idx_q;
							best_p_q <= aged;
							best_ser_q <= rd_s1.serial;
							best_e_q <= rd_s1;
						end
						if (last_idx) begin
							state_q <= S_SHIFT;
							idx_q <= (aged < best_p_q || (aged == best_p_q &&
								rd_s1.serial < best_ser_q)) ? idx_q : best_q;
						end else begin
							idx_q <= idx_q + IdxW'(1);
							state_q <= S_PSCAN;
						end
					end
				end
				S_SHIFT: begin
					// read idx+1 here, write it to idx in S_SHWR
					if (last_idx) state_q <= S_DONE;
					else state_q <= S_SHWR;
				end
				S_SHWR: begin
					idx_q <= idx_q + IdxW'(1);
					state_q <= S_SHIFT;
				end
				S_DONE: begin
					out_v_q <= 1'b1;
					state_q <= S_IDLE;
					if (func_q) begin
						out_st_q <= ST_OK;
						out_e_q <= best_e_q;
						count_q <= count_q - CntW'(1);
						if (count_q == CntW'(1)) begin
							serial_q <= 64'd1;
							disp_q <= '0;
						end else begin
							disp_q <= disp_q + 64'd1;
						end
					end else if (out_st_q == ST_OK) begin
						count_q <= count_q + CntW'(1);
						serial_q <= serial_q + 64'd1;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign m_tvalid = out_v_q;
	assign m_tuser = out_st_q;
	assign m_tdata = {out_e_q.dispatch, out_e_q.serial, out_e_q.size,
		out_e_q.handle, out_e_q.prio, out_e_q.sequence_num, out_e_q.epoch,
		out_e_q.schema, out_e_q.rclass};
endmodule
